FILE: hdl/fkin_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fkin_pkg
// Shared types and constants of the two-link arm forward kinematics core.
// ----------------------------------------------------------------------------
package fkin_pkg;

	localparam int ANGLE_BITS   = 16;
	localparam int CORDIC_STEPS = 30;
	// prep stage, iterations, round stage, multiply stage, output stage
	localparam int PIPE_DEPTH   = CORDIC_STEPS + 4;
	localparam int ST_SAT       = CORDIC_STEPS + 1;
	localparam int ST_MUL       = CORDIC_STEPS + 2;
	localparam int ST_OUT       = CORDIC_STEPS + 3;
	localparam int CW           = 34;
	localparam int ZW           = 33;
	localparam int PADDR_W      = 3;

	typedef logic [ANGLE_BITS-1:0] angle_t;
	typedef logic signed [CW-1:0]  cw_t;
	typedef logic signed [ZW-1:0]  cz_t;
	typedef logic signed [15:0]    q15_t;
	typedef logic [15:0]           len_t;
	typedef logic signed [17:0]    q512_t;

	typedef struct packed {
		cz_t  z;
		logic flip;
	} seed_t;

	typedef struct packed {
		logic ld_mul;
		logic ld_out;
	} mac_ctl_t;

	// 1/K in Q2.30
	localparam cw_t GAIN_INV = 34'sd652032874;

	localparam cz_t Z_QTR  = 33'sh0_4000_0000;
	localparam cz_t Z_HALF = 33'sh0_8000_0000;

	// atan(2^-i) as a fraction of a turn, 2^32 per turn
	localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
	};

endpackage
`default_nettype wire

FILE: hdl/fkin_prep.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fkin_prep
// Entry stage: forms both joint phases and folds them into the CORDIC range.
// ----------------------------------------------------------------------------
module fkin_prep (
	input  wire logic           clk,
	input  wire logic           load,
	input  wire logic [15:0]    shoulder_angle,
	input  wire logic [15:0]    elbow_angle,
	output fkin_pkg::seed_t     seed1_s1,
	output fkin_pkg::seed_t     seed12_s1
);
	import fkin_pkg::*;

	angle_t a1, a2, a12;
	seed_t  fold1, fold12;

	function automatic seed_t fold(angle_t a);
		logic [31:0] phase;
		cz_t         z;
		seed_t       r;
		phase = 32'(a) << (32 - ANGLE_BITS);
		z = cz_t'($signed(phase));
		r.flip = 1'b0;
		r.z = z;
		if (z > Z_QTR) begin
			r.z = z - Z_HALF;
			r.flip = 1'b1;
		end else if (z < -Z_QTR) begin
			r.z = z + Z_HALF;
			r.flip = 1'b1;
		end
		return r;
	endfunction

	assign a1  = angle_t'(shoulder_angle);
	assign a2  = angle_t'(elbow_angle);
	assign a12 = a1 + a2;

	assign fold1  = fold(a1);
	assign fold12 = fold(a12);

	always_ff @(posedge clk) begin
		if (load) begin
			seed1_s1  <= fold1;
			seed12_s1 <= fold12;
		end
	end

endmodule
`default_nettype wire

FILE: hdl/fkin_cordic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fkin_cordic
// Rotation-mode CORDIC, one iteration per pipeline stage, then a rounding
// stage that gives sine and cosine in saturated Q1.15.
// ----------------------------------------------------------------------------
module fkin_cordic (
	input  wire logic                               clk,
	input  wire logic [fkin_pkg::CORDIC_STEPS:0]    load,
	input  fkin_pkg::seed_t                         seed,
	output fkin_pkg::q15_t                          cos_s,
	output fkin_pkg::q15_t                          sin_s
);
	import fkin_pkg::*;

	cw_t  x_s    [CORDIC_STEPS+1];
	cw_t  y_s    [CORDIC_STEPS+1];
	cz_t  z_s    [CORDIC_STEPS+1];
	logic flip_s [CORDIC_STEPS+1];

	cw_t  xf, yf, xr, yr;

	function automatic q15_t sat_q15(cw_t v);
		if (v > 34'sd32767)
			return 16'sd32767;
		else if (v < -34'sd32767)
			return -16'sd32767;
		else
			return q15_t'(v);
	endfunction

	// stage 0 is the seed held by the prep stage
	always_comb begin
		x_s[0]    = GAIN_INV;
		y_s[0]    = '0;
		z_s[0]    = seed.z;
		flip_s[0] = seed.flip;
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
		cw_t dx, dy;
		cz_t at;
		assign dx = x_s[i] >>> i;
		assign dy = y_s[i] >>> i;
		assign at = cz_t'({1'b0, ATAN_TURN[i]});

		always_ff @(posedge clk) begin
			if (load[i]) begin
				flip_s[i+1] <= flip_s[i];
				if (!z_s[i][ZW-1]) begin
					x_s[i+1] <= x_s[i] - dy;
					y_s[i+1] <= y_s[i] + dx;
					z_s[i+1] <= z_s[i] - at;
				end else begin
					x_s[i+1] <= x_s[i] + dy;
					y_s[i+1] <= y_s[i] - dx;
					z_s[i+1] <= z_s[i] + at;
				end
			end
		end
	end

	// far half-plane was folded: negate back, then round half up
	assign xf = flip_s[CORDIC_STEPS] ? -x_s[CORDIC_STEPS] : x_s[CORDIC_STEPS];
	assign yf = flip_s[CORDIC_STEPS] ? -y_s[CORDIC_STEPS] : y_s[CORDIC_STEPS];
	assign xr = (xf + 34'sd16384) >>> 15;
	assign yr = (yf + 34'sd16384) >>> 15;

	always_ff @(posedge clk) begin
		if (load[CORDIC_STEPS]) begin
			cos_s <= sat_q15(xr);
			sin_s <= sat_q15(yr);
		end
	end

endmodule
`default_nettype wire

FILE: hdl/fkin_mac.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fkin_mac
// Scales the link directions by the link lengths, sums them and rounds the
// tip position to signed Q5.12.
// ----------------------------------------------------------------------------
module fkin_mac (
	input  wire logic           clk,
	input  fkin_pkg::mac_ctl_t  ctl,
	input  fkin_pkg::len_t      first_len,
	input  fkin_pkg::len_t      second_len,
	input  fkin_pkg::q15_t      cos1,
	input  fkin_pkg::q15_t      sin1,
	input  fkin_pkg::q15_t      cos12,
	input  fkin_pkg::q15_t      sin12,
	output fkin_pkg::q512_t     tip_x,
	output fkin_pkg::q512_t     tip_y
);
	import fkin_pkg::*;

	logic signed [32:0] px1_s, px2_s, py1_s, py2_s;
	logic signed [32:0] l1, l2;
	logic signed [33:0] sum_x, sum_y;

	assign l1 = 33'($signed({1'b0, first_len}));
	assign l2 = 33'($signed({1'b0, second_len}));

	always_ff @(posedge clk) begin
		if (ctl.ld_mul) begin
			px1_s <= l1 * 33'(cos1);
			px2_s <= l2 * 33'(cos12);
			py1_s <= l1 * 33'(sin1);
			py2_s <= l2 * 33'(sin12);
		end
	end

	assign sum_x = 34'(px1_s) + 34'(px2_s) + 34'sd16384;
	assign sum_y = 34'(py1_s) + 34'(py2_s) + 34'sd16384;

	always_ff @(posedge clk) begin
		if (ctl.ld_out) begin
			tip_x <= sum_x[32:15];
			tip_y <= sum_y[32:15];
		end
	end

endmodule
`default_nettype wire

FILE: hdl/two_link_arm_forward_kinematics_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// two_link_arm_forward_kinematics_core
// Tip position of a two-link planar arm from its two joint angles.
// ----------------------------------------------------------------------------
// One beat in and one beat out per cycle unless the output stalls. In order,
// one stage folds the angles, thirty stages run the CORDIC iterations (one
// iteration each, two CORDICs side by side for the shoulder angle and the
// angle sum), then a rounding stage, a multiply stage and the output register.
// A stall on the output holds a stage only when it and all stages after it are
// full; the rest keep filling, so input beats are taken until the pipe is packed.
// Link lengths are read straight from their registers; write them only while
// nothing is in flight. No clearing pass is needed after reset.
module two_link_arm_forward_kinematics_core (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [fkin_pkg::PADDR_W-1:0]       paddr,
	input  wire logic [31:0]                        pwdata,
	output logic [31:0]                             prdata,
	output logic                                    pready,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [15:0]                        shoulder_angle,
	input  wire logic [15:0]                        elbow_angle,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic signed [17:0]                      tip_x,
	output logic signed [17:0]                      tip_y
);
	import fkin_pkg::*;

	localparam logic REG_L1 = 1'b0;
	localparam logic REG_L2 = 1'b1;

	len_t                  first_len_q, second_len_q;
	logic [PIPE_DEPTH-1:0] vld_s;
	logic [PIPE_DEPTH-1:0] vld_in;
	logic [PIPE_DEPTH-1:0] rdy;
	logic                  cfg_wr;
	seed_t                 seed1_s1, seed12_s1;
	q15_t                  cos1, sin1, cos12, sin12;
	mac_ctl_t              mac_ctl;

	// ---------------- configuration ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_len_q  <= 16'd8192;
			second_len_q <= 16'd4096;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_L1: first_len_q  <= pwdata[15:0];
				REG_L2: second_len_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_L1:  prdata = {16'd0, first_len_q};
			REG_L2:  prdata = {16'd0, second_len_q};
			default: prdata = '0;
		endcase
	end

	// ---------------- pipeline control ----------------
	// a stage may load when the output is free or some stage from it onward is empty
	always_comb begin
		logic [PIPE_DEPTH-1:0] low;
		for (int k = 0; k < PIPE_DEPTH; k++) begin
			low    = (PIPE_DEPTH'(1) << k) - PIPE_DEPTH'(1);
			rdy[k] = !out_stall || ((vld_s | low) != '1);
		end
	end

	assign vld_in = {vld_s[PIPE_DEPTH-2:0], in_valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 0; k < PIPE_DEPTH; k++) begin
				if (rdy[k])
					vld_s[k] <= vld_in[k];
			end
		end
	end

	assign in_stall  = !rdy[0];
	assign out_valid = vld_s[ST_OUT];

	assign mac_ctl.ld_mul = rdy[ST_MUL];
	assign mac_ctl.ld_out = rdy[ST_OUT];

	// ---------------- datapath ----------------
	fkin_prep u_prep (
		.clk            (clk),
		.load           (rdy[0]),
		.shoulder_angle (shoulder_angle),
		.elbow_angle    (elbow_angle),
		.seed1_s1       (seed1_s1),
		.seed12_s1      (seed12_s1)
	);

	fkin_cordic u_cordic1 (
		.clk   (clk),
		.load  (rdy[ST_SAT:1]),
		.seed  (seed1_s1),
		.cos_s (cos1),
		.sin_s (sin1)
	);

	fkin_cordic u_cordic12 (
		.clk   (clk),
		.load  (rdy[ST_SAT:1]),
		.seed  (seed12_s1),
		.cos_s (cos12),
		.sin_s (sin12)
	);

	fkin_mac u_mac (
		.clk        (clk),
		.ctl        (mac_ctl),
		.first_len  (first_len_q),
		.second_len (second_len_q),
		.cos1       (cos1),
		.sin1       (sin1),
		.cos12      (cos12),
		.sin12      (sin12),
		.tip_x      (tip_x),
		.tip_y      (tip_y)
	);

endmodule
`default_nettype wire

FILE: hdl/fkin_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fkin_chk
// Port-level checks of the forward kinematics core, bound to the top level.
// ----------------------------------------------------------------------------
module fkin_chk (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pready,
	input  wire logic                           in_stall,
	input  wire logic                           out_valid,
	input  wire logic                           out_stall,
	input  wire logic signed [17:0]             tip_x,
	input  wire logic signed [17:0]             tip_y
);

	// a stalled result beat is held
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped under stall");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(tip_x) && $stable(tip_y))
		else $error("stalled result changed");

	// the pipe never holds off input while the output side is moving
	a_in_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || !out_stall |-> !in_stall)
		else $error("input stalled with output free");

	a_no_out_after_rst: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result beat right after reset");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable |-> pready)
		else $error("register access not completed");

endmodule

bind two_link_arm_forward_kinematics_core fkin_chk u_fkin_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.psel           (psel),
	.penable        (penable),
	.pready         (pready),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.tip_x          (tip_x),
	.tip_y          (tip_y)
);
`default_nettype wire

FILE: test/arm_tip_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// arm_tip_checker
// Tip position checker for the two-link arm forward kinematics core.
// ----------------------------------------------------------------------------
// Follows link length writes on the register bus. For every angle beat that
// is accepted it works out the tip position with its own CORDIC and stores
// it. Each result beat is then compared, field by field and in order, with
// the oldest stored tip.
module arm_tip_checker #(
	parameter logic [fkin_pkg::PADDR_W-1:0] FIRST_LINK_ADDR  = 3'd0,
	parameter logic [fkin_pkg::PADDR_W-1:0] SECOND_LINK_ADDR = 3'd4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fkin_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	input  logic                          pready,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [15:0]                   shoulder_angle,
	input  logic [15:0]                   elbow_angle,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  fkin_pkg::q512_t               tip_x,
	input  fkin_pkg::q512_t               tip_y,
	output int                            outstanding,
	output int                            fail_count,
	output int                            tips_checked
);
	import fkin_pkg::*;

	localparam len_t   FIRST_LINK_RESET  = 16'd8192;
	localparam len_t   SECOND_LINK_RESET = 16'd4096;
	localparam int     ROTATIONS         = 30;
	// 1/K of the rotation sequence, Q2.30
	localparam longint GAIN_Q30          = 64'sd652032874;
	localparam longint FULL_TURN         = 64'sd1 <<< 32;
	localparam longint HALF_TURN         = 64'sd1 <<< 31;
	localparam longint QUARTER_TURN      = 64'sd1 <<< 30;
	localparam longint UNIT_Q15          = 64'sd32767;

	// atan(2^-i) in units of 2^-32 turn
	localparam longint ATAN_STEP [ROTATIONS] = '{
		'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43,
		'h0145D7E1, 'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F,
		'h000A2F98, 'h000517CC, 'h00028BE6, 'h000145F3, 'h0000A2FA,
		'h0000517D, 'h000028BE, 'h0000145F, 'h00000A30, 'h00000518,
		'h0000028C, 'h00000146, 'h000000A3, 'h00000051, 'h00000029,
		'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001
	};

	typedef struct packed {
		angle_t shoulder;
		angle_t elbow;
		q512_t  x;
		q512_t  y;
	} tip_t;

	tip_t pending_tips [$];
	len_t first_len   = FIRST_LINK_RESET;
	len_t second_len  = SECOND_LINK_RESET;
	int   queue_depth = 0;
	int   mismatches  = 0;
	int   tip_count   = 0;

	assign outstanding  = queue_depth;
	assign fail_count   = mismatches;
	assign tips_checked = tip_count;

	// add one half, then floor
	function automatic longint round_down_shift(input longint v, input int sh);
		return (v + (64'sd1 <<< (sh - 1))) >>> sh;
	endfunction

	function automatic longint clamp_unit(input longint v);
		if (v > UNIT_Q15)
			return UNIT_Q15;
		if (v < -UNIT_Q15)
			return -UNIT_Q15;
		return v;
	endfunction

	function automatic void cordic_sincos(input angle_t angle, output longint sin_q15,
			output longint cos_q15);
		logic [31:0] phase;
		longint      x;
		longint      y;
		longint      z;
		longint      dx;
		longint      dy;
		bit          flip;
		phase = 32'(angle) << (32 - ANGLE_BITS);
		z     = {32'd0, phase};
		x     = GAIN_Q30;
		y     = 0;
		flip  = 1'b0;
		if (z >= HALF_TURN)
			z -= FULL_TURN;
		// fold the left half plane onto the right one
		if (z > QUARTER_TURN) begin
			z -= HALF_TURN;
			flip = 1'b1;
		end else if (z < -QUARTER_TURN) begin
			z += HALF_TURN;
			flip = 1'b1;
		end
		for (int i = 0; i < ROTATIONS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= ATAN_STEP[i];
			end else begin
				x += dx;
				y -= dy;
				z += ATAN_STEP[i];
			end
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		cos_q15 = clamp_unit(round_down_shift(x, 15));
		sin_q15 = clamp_unit(round_down_shift(y, 15));
	endfunction

	function automatic tip_t tip_position(input angle_t shoulder, input angle_t elbow,
			input len_t len1, input len_t len2);
		tip_t   t;
		angle_t sum;
		longint s1;
		longint c1;
		longint s12;
		longint c12;
		longint k1;
		longint k2;
		sum = shoulder + elbow;
		cordic_sincos(shoulder, s1, c1);
		cordic_sincos(sum, s12, c12);
		k1 = len1;
		k2 = len2;
		t.shoulder = shoulder;
		t.elbow    = elbow;
		t.x        = q512_t'(round_down_shift(k1 * c1 + k2 * c12, 15));
		t.y        = q512_t'(round_down_shift(k1 * s1 + k2 * s12, 15));
		return t;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tip_t want;
		if (!arst_n) begin
			first_len   <= FIRST_LINK_RESET;
			second_len  <= SECOND_LINK_RESET;
			queue_depth <= 0;
			pending_tips.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr == FIRST_LINK_ADDR)
					first_len <= pwdata[15:0];
				else if (paddr == SECOND_LINK_ADDR)
					second_len <= pwdata[15:0];
			end
			if (in_valid && !in_stall)
				pending_tips = {pending_tips, tip_position(angle_t'(shoulder_angle),
					angle_t'(elbow_angle), first_len, second_len)};
			if (out_valid && !out_stall) begin
				if (pending_tips.size() == 0) begin
					mismatches++;
					$display("%0t: tip beat with nothing expected, x %0d y %0d",
						$time, tip_x, tip_y);
				end else begin
					want = pending_tips.pop_front();
					tip_count++;
					if (tip_x !== want.x) begin
						mismatches++;
						$display("%0t: tip_x expected %0d, got %0d (shoulder %h elbow %h)",
							$time, want.x, tip_x, want.shoulder, want.elbow);
					end
					if (tip_y !== want.y) begin
						mismatches++;
						$display("%0t: tip_y expected %0d, got %0d (shoulder %h elbow %h)",
							$time, want.y, tip_y, want.shoulder, want.elbow);
					end
				end
			end
			queue_depth <= pending_tips.size();
		end
	end

endmodule

FILE: test/tb_two_link_arm_forward_kinematics_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_two_link_arm_forward_kinematics_core
// Stimulus and verdict for the two-link arm forward kinematics core.
// ----------------------------------------------------------------------------
// Sends directed angle beats at the quadrant and wrap boundaries, then random
// beats under a series of link lengths from zero to full scale. Both sides
// idle at random, with stretches of full rate; once the output is held long
// enough to back the pipe up into the input. The checker beside the core
// predicts and compares every result beat.
module tb_two_link_arm_forward_kinematics_core;
	import fkin_pkg::*;

	localparam logic [PADDR_W-1:0] ADDR_FIRST_LINK  = 3'd0;
	localparam logic [PADDR_W-1:0] ADDR_SECOND_LINK = 3'd4;
	localparam int NUM_SETTINGS = 8;
	localparam int NUM_DIRECTED = 16;
	localparam int MAX_GAP      = 6;
	localparam int LONG_HOLD    = 300;
	localparam int DRAIN_CYCLES = 100;

	localparam angle_t DIR_SHOULDER [NUM_DIRECTED] = '{
		16'h0000, 16'hFFFF, 16'h4000, 16'h8000, 16'hC000, 16'h4000, 16'h8000, 16'hFFFF,
		16'h0001, 16'h2000, 16'h3FFF, 16'hC001, 16'hAAAA, 16'h5555, 16'h4001, 16'h7FFF
	};
	localparam angle_t DIR_ELBOW [NUM_DIRECTED] = '{
		16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h8000, 16'h0001,
		16'hFFFF, 16'h6000, 16'h0002, 16'h7FFF, 16'h5555, 16'hAAAA, 16'hBFFF, 16'h8001
	};

	logic               clk            = 1'b0;
	logic               arst_n         = 1'b0;
	logic               psel           = 1'b0;
	logic               penable        = 1'b0;
	logic               pwrite         = 1'b0;
	logic [PADDR_W-1:0] paddr          = '0;
	logic [31:0]        pwdata         = '0;
	logic               in_valid       = 1'b0;
	logic [15:0]        shoulder_angle = '0;
	logic [15:0]        elbow_angle    = '0;
	logic               out_stall      = 1'b0;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_stall;
	logic               out_valid;
	q512_t              tip_x;
	q512_t              tip_y;
	int                 outstanding;
	int                 fail_count;
	int                 tips_checked;
	bit                 idle_on        = 1'b1;
	bit                 hold_request   = 1'b0;

	two_link_arm_forward_kinematics_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.shoulder_angle (shoulder_angle),
		.elbow_angle    (elbow_angle),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.tip_x          (tip_x),
		.tip_y          (tip_y)
	);

	arm_tip_checker #(
		.FIRST_LINK_ADDR  (ADDR_FIRST_LINK),
		.SECOND_LINK_ADDR (ADDR_SECOND_LINK)
	) chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.shoulder_angle (shoulder_angle),
		.elbow_angle    (elbow_angle),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.tip_x          (tip_x),
		.tip_y          (tip_y),
		.outstanding    (outstanding),
		.fail_count     (fail_count),
		.tips_checked   (tips_checked)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("timeout waiting for tip beats");
		$display("status: fail");
		$finish;
	end

	// upper data bits are junk, only the low 16 bits hold the length
	task automatic write_length(input logic [PADDR_W-1:0] addr, input len_t len);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= {16'($urandom()), len};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic send_beat(input angle_t shoulder, input angle_t elbow);
		int gap;
		gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid       <= 1'b1;
		shoulder_angle <= shoulder;
		elbow_angle    <= elbow;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// mostly uniform, sometimes just around a quadrant boundary
	function automatic angle_t rand_angle();
		if ($urandom_range(0, 9) < 7)
			return angle_t'($urandom());
		return angle_t'($urandom_range(0, 3) << (ANGLE_BITS - 2))
			+ angle_t'($urandom_range(0, 4)) - angle_t'(2);
	endfunction

	// result side
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			if (hold_request) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				hold_request = 1'b0;
			end
			stall = idle_on ? $urandom_range(0, MAX_GAP) : 0;
			if (stall != 0) begin
				out_stall <= 1'b1;
				repeat (stall) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		len_t   len1;
		len_t   len2;
		angle_t a1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		for (int i = 0; i < NUM_DIRECTED; i++)
			send_beat(DIR_SHOULDER[i], DIR_ELBOW[i]);
		wait_drained();
		for (int p = 0; p < NUM_SETTINGS; p++) begin
			if (p != 0) begin
				case (p)
					1: begin
						len1 = '1;
						len2 = '1;
					end
					2: begin
						len1 = '0;
						len2 = '0;
					end
					3: begin
						len1 = '0;
						len2 = '1;
					end
					4: begin
						len1 = '1;
						len2 = '0;
					end
					7: begin
						len1 = 16'd8192;
						len2 = 16'd4096;
					end
					default: begin
						len1 = len_t'($urandom());
						len2 = len_t'($urandom());
					end
				endcase
				write_length(ADDR_FIRST_LINK, len1);
				write_length(ADDR_SECOND_LINK, len2);
			end
			idle_on = (p % 3 != 1);
			// full links and a long output hold while the input streams at full rate
			if (p == 1)
				hold_request = 1'b1;
			repeat (p == 0 ? 40 : 87) begin
				a1 = rand_angle();
				send_beat(a1, ($urandom_range(0, 7) == 0) ? angle_t'(-a1) : rand_angle());
			end
			wait_drained();
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d tip beats over %0d link length settings, zero and full scale",
			tips_checked, NUM_SETTINGS);
		$display("angles at quadrant and wrap edges; output held %0d cycles to back up the pipe",
			LONG_HOLD);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
